FILE: sv/kts_pkg.sv
// Shared types and constants for the KMP text search block.
package kts_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int LINE_WIDTH_DEF  = 80;
  localparam int BYTE_W          = 8;
  localparam int OP_W            = 2;
  localparam int TEXT_W          = 16;
  localparam int COL_W           = 7;
  localparam int QDEPTH          = 2;
  localparam int QPW             = 1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_TEXT    = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef struct packed {
    op_t               kind;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_MATCH
  } st_t;

endpackage

FILE: sv/kmp_text_search.sv
// Top level of the streaming KMP text search block.
// Streaming Knuth-Morris-Pratt matcher. Each request carries an op: clear
// pattern, append one pattern byte, one text byte, or restart the text scan.
// Appends build the failure table online; appends beyond
// min(MAX_PATTERN, LINE_WIDTH-1) bytes are ignored. Each text byte that
// completes the pattern gives one result with the 0-based start index and
// the 1-based column and line for lines of LINE_WIDTH characters; the scan
// then restarts, so matches never overlap. The text index saturates at 65535.
// A two-entry request queue decouples the input from the matching engine,
// and a result register decouples the engine from the output, so a stall on
// either side is absorbed until the queue or the result register is full.
// Clear, restart, an ignored append, an append to an empty pattern and a
// text byte with no pattern loaded are done in the idle state as they are
// dequeued. Other appends and text bytes are dequeued in the idle state,
// then walk the KMP pointer: each step that compares passes through a read
// state (pattern/failure RAM read) and a compare state, and a step that has
// fallen back to zero ends in the read state alone. A byte that completes
// a match then passes through the match state, which loads the result
// register, and waits there while an earlier result is held by the output
// stall. The single read port of the pattern and failure RAMs is why every
// compare needs its own read state. No clearing pass is needed after reset.
module kmp_text_search import kts_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int LINE_WIDTH  = LINE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_op,
  input  logic [BYTE_W-1:0] in_byte_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TEXT_W-1:0] out_match_start_index,
  output logic [COL_W-1:0]  out_match_column,
  output logic [TEXT_W-1:0] out_match_line
);

  head_t head;  // oldest queued request
  logic  pop;   // engine takes the queue head

  // front: accept and classify requests into the queue
  kts_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_byte_value (in_byte_value),
    .head          (head),
    .pop           (pop)
  );

  // back: table build, text matching and result register
  kts_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .LINE_WIDTH  (LINE_WIDTH)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head                  (head),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_match_start_index (out_match_start_index),
    .out_match_column      (out_match_column),
    .out_match_line        (out_match_line)
  );

endmodule

FILE: sv/kts_ram.sv
// Generic simple dual-port RAM with registered read.
module kts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/kts_front.sv
// Front end: takes requests, classifies the op and queues them for the back end.
module kts_front import kts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_op,
  input  logic [BYTE_W-1:0] in_byte_value,
  output head_t             head,
  input  logic              pop
);

  cmd_t             q_r [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPW:0]     count_r, count_nxt;
  logic             push;
  logic             do_pop;
  cmd_t             cmd_in;

  always_comb begin
    cmd_in.kind = op_t'(in_op);
    // payload byte only matters for pattern and text requests
    cmd_in.data = (cmd_in.kind == OP_APPEND || cmd_in.kind == OP_TEXT) ?
                  in_byte_value : '0;
  end

  assign in_stall   = (count_r == (QPW+1)'(QDEPTH));
  assign push       = in_valid && !in_stall;
  assign do_pop     = pop && (count_r != '0);
  assign head.valid = (count_r != '0);
  assign head.cmd   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPW+1)'(push) - (QPW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPW+1)'(QDEPTH))
    else $error("queue count overflow");
`endif

endmodule

FILE: sv/kts_back.sv
// Back end: pattern load with online failure table build, and text matching.
module kts_back import kts_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int LINE_WIDTH  = LINE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  head_t             head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TEXT_W-1:0] out_match_start_index,
  output logic [COL_W-1:0]  out_match_column,
  output logic [TEXT_W-1:0] out_match_line
);

  localparam int PW    = $clog2(MAX_PATTERN + 1);
  localparam int PAW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int RW    = $clog2(LINE_WIDTH);
  localparam int CW    = RW + 1;
  localparam int LIMIT = (LINE_WIDTH - 1 < MAX_PATTERN) ? LINE_WIDTH - 1 : MAX_PATTERN;
  localparam logic [TEXT_W-1:0] TI_MAX = '1;

  st_t               state_r, state_nxt;
  logic              build_r, build_nxt;
  logic [PW-1:0]     len_r, len_nxt;
  logic [PW-1:0]     bp_r, bp_nxt;
  logic [PW-1:0]     mp_r, mp_nxt;
  logic [PW-1:0]     j_r, j_nxt;
  logic [BYTE_W-1:0] last_r, last_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [TEXT_W-1:0] ti_r, ti_nxt;
  logic [TEXT_W-1:0] tq_r, tq_nxt;
  logic [RW-1:0]     tr_r, tr_nxt;
  logic [TEXT_W-1:0] sidx_r, sidx_nxt;
  logic [TEXT_W-1:0] sq_r, sq_nxt;
  logic [RW-1:0]     sr_r, sr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [TEXT_W-1:0] out_idx_r, out_idx_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [TEXT_W-1:0] out_line_r, out_line_nxt;

  logic              pat_we, rd_en;
  logic [PAW-1:0]    pat_waddr, pat_raddr;
  logic [BYTE_W-1:0] pat_wdata, pat_rdata;
  logic              fail_we;
  logic [PW-1:0]     fail_waddr, fail_raddr;
  logic [PW-1:0]     fail_wdata, fail_rdata;

  logic              fin;
  logic [PW-1:0]     fin_j;
  logic [PW:0]       jn;
  logic [BYTE_W-1:0] key;
  logic [TEXT_W-1:0] back16;
  logic [CW-1:0]     back_c, tr_c, sr_c;

  kts_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PATTERN)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (pat_wdata),
    .re    (rd_en),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  kts_ram #(.WIDTH(PW), .DEPTH(MAX_PATTERN + 1)) u_fail_ram (
    .clk   (clk),
    .we    (fail_we),
    .waddr (fail_waddr),
    .wdata (fail_wdata),
    .re    (rd_en),
    .raddr (fail_raddr),
    .rdata (fail_rdata)
  );

  // start position of a match ending at the current text index
  assign back16 = TEXT_W'(len_r) - TEXT_W'(1);
  assign back_c = CW'(len_r - PW'(1));
  assign tr_c   = CW'(tr_r);

  assign key        = build_r ? last_r : byte_r;
  assign pat_raddr  = PAW'(j_r - PW'(1));
  assign fail_raddr = j_r;
  assign jn         = {1'b0, fin_j} + (PW+1)'(1);

  always_comb begin
    state_nxt     = state_r;
    build_nxt     = build_r;
    len_nxt       = len_r;
    bp_nxt        = bp_r;
    mp_nxt        = mp_r;
    j_nxt         = j_r;
    last_nxt      = last_r;
    byte_nxt      = byte_r;
    ti_nxt        = ti_r;
    tq_nxt        = tq_r;
    tr_nxt        = tr_r;
    sidx_nxt      = sidx_r;
    sq_nxt        = sq_r;
    sr_nxt        = sr_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_col_nxt   = out_col_r;
    out_line_nxt  = out_line_r;
    pop           = 1'b0;
    pat_we        = 1'b0;
    pat_waddr     = PAW'(len_r);
    pat_wdata     = head.cmd.data;
    fail_we       = 1'b0;
    fail_waddr    = len_r + PW'(1);
    fail_wdata    = jn[PW-1:0];
    rd_en         = 1'b0;
    fin           = 1'b0;
    fin_j         = j_r;
    sr_c          = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop      = 1'b1;
          byte_nxt = head.cmd.data;
          case (head.cmd.kind)
            OP_CLEAR: begin
              len_nxt = '0;
              bp_nxt  = '0;
              mp_nxt  = PW'(1);
            end
            OP_APPEND: begin
              if (len_r < PW'(LIMIT)) begin
                pat_we = 1'b1;
                if (len_r == '0) begin
                  fail_we    = 1'b1;
                  fail_waddr = PW'(1);
                  fail_wdata = '0;
                  len_nxt    = PW'(1);
                  bp_nxt     = '0;
                  mp_nxt     = PW'(1);
                  last_nxt   = head.cmd.data;
                end else begin
                  build_nxt = 1'b1;
                  j_nxt     = bp_r;
                  state_nxt = ST_RD;
                end
              end
            end
            OP_TEXT: begin
              if (ti_r != TI_MAX) begin
                ti_nxt = ti_r + TEXT_W'(1);
                if (tr_r == RW'(LINE_WIDTH - 1)) begin
                  tr_nxt = '0;
                  tq_nxt = tq_r + TEXT_W'(1);
                end else begin
                  tr_nxt = tr_r + RW'(1);
                end
              end
              if (len_r != '0) begin
                build_nxt = 1'b0;
                j_nxt     = (mp_r == '0 || mp_r > len_r) ? PW'(1) : mp_r;
                state_nxt = ST_RD;
                // start coordinates, clamped at the head of the text
                sidx_nxt  = (ti_r >= back16) ? ti_r - back16 : '0;
                if (tr_c >= back_c) begin
                  sr_c   = tr_c - back_c;
                  sq_nxt = tq_r;
                end else if (tq_r == '0) begin
                  sr_c   = '0;
                  sq_nxt = '0;
                end else begin
                  sr_c   = tr_c + CW'(LINE_WIDTH) - back_c;
                  sq_nxt = tq_r - TEXT_W'(1);
                end
                sr_nxt = RW'(sr_c);
              end
            end
            OP_RESTART: begin
              ti_nxt = '0;
              tq_nxt = '0;
              tr_nxt = '0;
              mp_nxt = PW'(1);
            end
            default: begin
            end
          endcase
        end
      end

      ST_RD: begin
        if (j_r == '0) begin
          fin   = 1'b1;
          fin_j = '0;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_CMP;
        end
      end

      ST_CMP: begin
        if (key == pat_rdata) begin
          fin   = 1'b1;
          fin_j = j_r;
        end else begin
          j_nxt     = fail_rdata;
          state_nxt = ST_RD;
        end
      end

      ST_MATCH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = sidx_r;
          out_col_nxt   = COL_W'(CW'(sr_r) + CW'(1));
          out_line_nxt  = (sq_r == TI_MAX) ? sq_r : sq_r + TEXT_W'(1);
          mp_nxt        = PW'(1);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (build_r) begin
        fail_we   = 1'b1;
        bp_nxt    = jn[PW-1:0];
        len_nxt   = len_r + PW'(1);
        mp_nxt    = PW'(1);
        last_nxt  = byte_r;
        state_nxt = ST_IDLE;
      end else if (jn > {1'b0, len_r}) begin
        state_nxt = ST_MATCH;
      end else begin
        mp_nxt    = jn[PW-1:0];
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      bp_r        <= '0;
      mp_r        <= PW'(1);
      ti_r        <= '0;
      tq_r        <= '0;
      tr_r        <= '0;
      build_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      bp_r        <= bp_nxt;
      mp_r        <= mp_nxt;
      ti_r        <= ti_nxt;
      tq_r        <= tq_nxt;
      tr_r        <= tr_nxt;
      build_r     <= build_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    last_r     <= last_nxt;
    byte_r     <= byte_nxt;
    sidx_r     <= sidx_nxt;
    sq_r       <= sq_nxt;
    sr_r       <= sr_nxt;
    out_idx_r  <= out_idx_nxt;
    out_col_r  <= out_col_nxt;
    out_line_r <= out_line_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_match_start_index = out_idx_r;
  assign out_match_column      = out_col_r;
  assign out_match_line        = out_line_r;

`ifndef SYNTHESIS
  a_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= PW'(LIMIT))
    else $error("pattern length beyond limit");

  a_mp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    mp_r != '0)
    else $error("match pointer is zero");

  a_bp_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    len_r == '0 || bp_r < len_r)
    else $error("build pointer not below pattern length");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD || state_r == ST_CMP) |-> j_r <= len_r)
    else $error("fallback pointer beyond pattern");

  a_match_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MATCH && out_valid_r && out_stall) |=> state_r == ST_MATCH)
    else $error("match dropped while output stalled");
`endif

endmodule

FILE: tb/sv/kmp_text_search_test.sv
// Self-checking testbench for the streaming KMP text search block.
module kmp_text_search_test import kts_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Pattern capacity: the block ignores appends past min(MAX_PATTERN, LINE_WIDTH-1).
  localparam int PAT_CAP     = (MAX_PATTERN_DEF < LINE_WIDTH_DEF - 1) ?
                               MAX_PATTERN_DEF : LINE_WIDTH_DEF - 1;
  localparam int TEXT_MAX    = 65535;
  localparam int RANDOM_REQS = 1100;
  localparam int FINAL_TEXT  = 120;
  // Worst text byte walks ~32 fallback steps, each a RAM read and a compare, plus stalls.
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef struct packed {
    logic [TEXT_W-1:0] start;
    logic [COL_W-1:0]  column;
    logic [TEXT_W-1:0] line;
  } match_t;

  // Scoreboard: mirrors pattern store, failure table and scan pointers, and
  // keeps the matches still owed by the block in arrival order.
  class match_scoreboard;
    logic [BYTE_W-1:0] pat [1:MAX_PATTERN_DEF];
    logic [5:0]        fail_link [0:MAX_PATTERN_DEF];
    int unsigned       plen;
    int unsigned       build_ptr;
    int unsigned       scan_ptr;
    int unsigned       text_pos;
    match_t            expected_matches [$];
    int unsigned       errors;

    function new();
      plen      = 0;
      build_ptr = 0;
      scan_ptr  = 1;
      text_pos  = 0;
      errors    = 0;
      foreach (pat[k]) pat[k] = '0;
      foreach (fail_link[k]) fail_link[k] = '0;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    // Online failure-table extension; returns 0 when the pattern is full.
    function bit append_pattern_byte(logic [BYTE_W-1:0] b);
      int unsigned m;
      int unsigned j;
      if (plen >= PAT_CAP) return 1'b0;
      m = plen + 1;
      pat[m] = b;
      if (m == 1) begin
        fail_link[1] = '0;
        build_ptr    = 0;
      end else begin
        j = build_ptr;
        while (j != 0 && pat[m-1] != pat[j]) j = fail_link[j];
        j++;
        fail_link[m] = j[5:0];
        build_ptr    = j;
      end
      plen     = m;
      scan_ptr = 1;
      return 1'b1;
    endfunction

    function void scan_text_byte(logic [BYTE_W-1:0] c);
      int unsigned pos;
      int unsigned j;
      int unsigned back;
      int unsigned s;
      int unsigned ln;
      match_t      hit;
      pos = text_pos;
      if (text_pos < TEXT_MAX) text_pos++;
      if (plen == 0) return;
      j = scan_ptr;
      if (j < 1 || j > plen) j = 1;
      while (j != 0 && c != pat[j]) j = fail_link[j];
      j++;
      if (j > plen) begin
        back = plen - 1;
        s    = (pos >= back) ? pos - back : 0;
        ln   = s / LINE_WIDTH_DEF + 1;
        if (ln > TEXT_MAX) ln = TEXT_MAX;
        hit.start  = s[TEXT_W-1:0];
        hit.column = COL_W'(s % LINE_WIDTH_DEF + 1);
        hit.line   = ln[TEXT_W-1:0];
        expected_matches.push_back(hit);
        j = 1;
      end
      scan_ptr = j;
    endfunction

    // Returns 0 only for an append the block drops.
    function bit apply_request(op_t op, logic [BYTE_W-1:0] b);
      case (op)
        OP_CLEAR: begin
          plen      = 0;
          build_ptr = 0;
          scan_ptr  = 1;
        end
        OP_APPEND: return append_pattern_byte(b);
        OP_TEXT: scan_text_byte(b);
        default: begin
          text_pos = 0;
          scan_ptr = 1;
        end
      endcase
      return 1'b1;
    endfunction

    task check_match(logic [TEXT_W-1:0] s, logic [COL_W-1:0] c, logic [TEXT_W-1:0] l);
      match_t want;
      if (expected_matches.size() == 0) begin
        report($sformatf("unexpected match start=%0d col=%0d line=%0d", s, c, l));
        return;
      end
      want = expected_matches.pop_front();
      if (s !== want.start)
        report($sformatf("start index %0d, want %0d", s, want.start));
      if (c !== want.column)
        report($sformatf("column %0d, want %0d (start %0d)", c, want.column, want.start));
      if (l !== want.line)
        report($sformatf("line %0d, want %0d (start %0d)", l, want.line, want.start));
    endtask
  endclass

  logic              clk;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  op_t               in_op         = OP_CLEAR;
  logic [BYTE_W-1:0] in_byte_value = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [TEXT_W-1:0] out_match_start_index;
  logic [COL_W-1:0]  out_match_column;
  logic [TEXT_W-1:0] out_match_line;

  match_scoreboard sb = new();

  int unsigned in_idle_pct   = 0;  // chance of a send gap before a request
  int unsigned out_stall_pct = 0;  // chance of a stall burst starting
  int unsigned stall_left    = 0;
  int unsigned counted_reqs  = 0;  // requests that had an effect
  longint unsigned cycles    = 0;

  kmp_text_search dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_op                (in_op),
    .in_byte_value        (in_byte_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_match_start_index(out_match_start_index),
    .out_match_column     (out_match_column),
    .out_match_line       (out_match_line)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: any hang or a lost handshake ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("kmp_text_search_test NOT OK");
      $finish;
    end
  end

  // Receiver back-pressure: random stall bursts.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (rst_n && $urandom_range(0, 99) < out_stall_pct) begin
      stall_left <= $urandom_range(0, 4);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor: every accepted match is checked at the edge it transfers.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_match(out_match_start_index, out_match_column, out_match_line);
  end

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // One request: optional send gap, then hold until the block takes it.
  task automatic send_req(op_t op, logic [BYTE_W-1:0] b);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_byte_value <= b;
    do @(posedge clk); while (in_stall);
    if (sb.apply_request(op, b)) counted_reqs++;
    @(negedge clk);
  endtask

  // Feed the currently loaded pattern as text, so a match is sure to form.
  task automatic plant_pattern();
    int unsigned n;
    n = sb.plen;
    for (int unsigned k = 1; k <= n; k++) send_req(OP_TEXT, sb.pat[k]);
  endtask

  // One random phase: load a pattern from a tiny alphabet, then scan text
  // drawn mostly from the same alphabet so partial matches and fallbacks are
  // frequent; a minority of requests are restarts, clears, mid-scan appends
  // and arbitrary bytes.
  task automatic run_phase(bit force_full);
    logic [BYTE_W-1:0] alpha [3];
    int unsigned       n_alpha;
    int unsigned       plen_goal;
    int unsigned       n_text;
    int unsigned       r;
    case ($urandom_range(0, 2))
      0: in_idle_pct = 0;
      1: in_idle_pct = 20;
      default: in_idle_pct = 50;
    endcase
    case ($urandom_range(0, 2))
      0: out_stall_pct = 0;
      1: out_stall_pct = 15;
      default: out_stall_pct = 40;
    endcase
    n_alpha = $urandom_range(1, 3);
    foreach (alpha[k]) alpha[k] = rand_byte();
    // Mostly short patterns; now and then one long enough to overflow.
    if (force_full || $urandom_range(0, 9) == 0)
      plen_goal = $urandom_range(PAT_CAP - 4, PAT_CAP + 8);
    else plen_goal = $urandom_range(1, 6);
    if ($urandom_range(0, 3) != 0) send_req(OP_CLEAR, rand_byte());
    repeat (plen_goal) send_req(OP_APPEND, alpha[$urandom_range(0, n_alpha - 1)]);
    n_text = $urandom_range(10, 50);
    repeat (n_text) begin
      r = $urandom_range(0, 99);
      if (r < 8) plant_pattern();
      else if (r < 85) send_req(OP_TEXT, alpha[$urandom_range(0, n_alpha - 1)]);
      else if (r < 91) send_req(OP_TEXT, rand_byte());
      else if (r < 94) send_req(OP_RESTART, rand_byte());
      else if (r < 97) send_req(OP_APPEND, alpha[$urandom_range(0, n_alpha - 1)]);
      else send_req(OP_CLEAR, rand_byte());
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] pa;
    logic [BYTE_W-1:0] pb;
    logic [BYTE_W-1:0] filler;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty pattern, byte extremes, fallback, append mid-scan,
    // restart and clear.
    send_req(OP_CLEAR, 8'h00);
    send_req(OP_TEXT, 8'h41);         // no pattern: index only
    send_req(OP_APPEND, 8'h00);
    send_req(OP_APPEND, 8'hFF);
    send_req(OP_TEXT, 8'h00);
    send_req(OP_TEXT, 8'hFF);         // direct match
    send_req(OP_TEXT, 8'h00);
    send_req(OP_TEXT, 8'h00);         // mismatch then fallback
    send_req(OP_TEXT, 8'hFF);
    send_req(OP_TEXT, 8'h00);         // partial match ...
    send_req(OP_APPEND, 8'h00);       // ... dropped by the append
    send_req(OP_TEXT, 8'hFF);
    send_req(OP_TEXT, 8'h00);
    send_req(OP_TEXT, 8'h00);
    send_req(OP_TEXT, 8'hFF);
    send_req(OP_TEXT, 8'h00);
    send_req(OP_RESTART, 8'hFF);      // index back to zero
    send_req(OP_TEXT, 8'h00);
    send_req(OP_TEXT, 8'hFF);
    send_req(OP_TEXT, 8'h00);
    send_req(OP_CLEAR, 8'hFF);
    send_req(OP_TEXT, 8'h55);         // cleared: no match possible

    // Random phases, the first with a pattern pushed past capacity.
    counted_reqs = 0;
    run_phase(1'b1);
    while (counted_reqs < RANDOM_REQS) run_phase(1'b0);

    // Final stretch, no idling: filler text with a match now and then, a
    // one-byte pattern, a longer one, and a restart.
    in_idle_pct   = 0;
    out_stall_pct = 0;
    pa = rand_byte();
    do pb = rand_byte(); while (pb == pa);
    do filler = rand_byte(); while (filler == pa || filler == pb);
    send_req(OP_CLEAR, filler);
    send_req(OP_APPEND, pa);
    send_req(OP_APPEND, pb);
    repeat (FINAL_TEXT) begin
      if ($urandom_range(0, 9) == 0) plant_pattern();
      else send_req(OP_TEXT, filler);
    end
    send_req(OP_TEXT, filler);
    send_req(OP_CLEAR, filler);
    send_req(OP_APPEND, pa);
    repeat (2) plant_pattern();       // one-byte pattern, back to back
    send_req(OP_APPEND, pb);
    send_req(OP_APPEND, pa);
    send_req(OP_APPEND, pb);
    plant_pattern();
    send_req(OP_RESTART, filler);
    plant_pattern();
    in_valid <= 1'b0;

    while (sb.expected_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_matches.size() != 0)
      sb.report($sformatf("%0d matches never arrived", sb.expected_matches.size()));

    if (sb.errors == 0) begin
      $display("kmp_text_search_test OK");
    end else begin
      $display("kmp_text_search_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: kmp_text_search.f
sv/kts_pkg.sv
sv/kts_ram.sv
sv/kts_front.sv
sv/kts_back.sv
sv/kmp_text_search.sv
tb/sv/kmp_text_search_test.sv
